/* rtl/core/vcr_pkg.sv */
// package for the voxel color reconstruction block
// default sizes, the color method codes and the sample struct; no dependencies
`default_nettype none

package vcr_pkg;

  // default store depth and weight width
  localparam int unsigned MaxSamplesDef = 64;
  localparam int unsigned WeightBitsDef = 16;

  // color method register codes
  typedef enum logic [1:0] {
    METHOD_AVERAGE  = 2'd0,
    METHOD_BEST     = 2'd1,
    METHOD_WEIGHTED = 2'd2,
    METHOD_MEDIAN   = 2'd3
  } method_e;

  // one sample as kept in the store: red high, blue low
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

/* rtl/core/vcr_ram.sv */
// generic simple dual-port ram with registered read
// one write port, one read port; no dependencies
`default_nettype none

module vcr_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/voxel_color_reconstruction_top.sv */
// Samples arrive one per cycle on the input stream; sums, total weight and best view are
// updated as each item is taken while the store has room, and its color is written to the
// sample ram. After the last item (tlast) the block works out the color and holds it in an
// output register, so a new voxel is taken while the result waits. Best view goes straight
// to the output state; average and weighted average run in the shared 1-bit-per-cycle
// divider, channel by channel; median takes one radix pass over the sample ram per result
// bit (all three channels and both middle ranks at once). The output state loads the
// output register and waits there while an earlier result is still held. No items are
// taken while a voxel finishes.
// depends on vcr_pkg and vcr_ram
`default_nettype none

module voxel_color_reconstruction_top #(
  parameter int unsigned MAX_SAMPLES = vcr_pkg::MaxSamplesDef,
  parameter int unsigned WEIGHT_BITS = vcr_pkg::WeightBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // apb configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // red, green, blue, view_weight
  input  wire logic        s_axis_tlast,  // final_sample
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // out_red, out_green, out_blue
  output logic             m_axis_tuser   // capacity_exceeded
);

  import vcr_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AddrW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned PlainW = 8 + CntW;
  localparam int unsigned TotW = WEIGHT_BITS + CntW;
  localparam int unsigned WSumW = WEIGHT_BITS + 8 + CntW;
  localparam int unsigned NumW = WSumW + 2;
  localparam int unsigned DvsW = NumW + 8;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DIV_LD   = 7'b0000010,
    ST_DIV_RUN  = 7'b0000100,
    ST_MED_RD   = 7'b0001000,
    ST_MED_WAIT = 7'b0010000,
    ST_MED_BIT  = 7'b0100000,
    ST_OUT      = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // configuration register
  method_e method_q;
  assign pready = 1'b1;
  assign prdata = {30'd0, method_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      method_q <= METHOD_AVERAGE;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      method_q <= method_e'(pwdata[1:0]);
    end
  end

  // input fields
  rgb_t                   in_rgb;
  logic [WEIGHT_BITS-1:0] in_w;
  assign in_rgb = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};

  if (WEIGHT_BITS >= 16) begin : g_wide_w
    assign in_w = WEIGHT_BITS'(s_axis_tdata[39:24]);
  end else begin : g_narrow_w
    assign in_w = s_axis_tdata[24 +: WEIGHT_BITS];
  end

  // voxel accumulators
  logic [CntW-1:0]        cnt_q;
  logic [PlainW-1:0]      psum_q [3];
  logic [WSumW-1:0]       wsum_q [3];
  logic [TotW-1:0]        tot_q;
  logic [WEIGHT_BITS-1:0] best_w_q;
  rgb_t                   best_q;
  logic                   ovf_q;

  logic accept, room, clear_vox;
  logic [7:0] in_ch [3];
  assign in_ch[0] = in_rgb.red;
  assign in_ch[1] = in_rgb.green;
  assign in_ch[2] = in_rgb.blue;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign room = (cnt_q < CntW'(MAX_SAMPLES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      tot_q    <= '0;
      best_w_q <= '0;
      best_q   <= '0;
      ovf_q    <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        psum_q[c] <= '0;
        wsum_q[c] <= '0;
      end
    end else if (clear_vox) begin
      cnt_q    <= '0;
      tot_q    <= '0;
      best_w_q <= '0;
      best_q   <= '0;
      ovf_q    <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        psum_q[c] <= '0;
        wsum_q[c] <= '0;
      end
    end else if (accept) begin
      if (room) begin
        cnt_q <= cnt_q + 1'b1;
        tot_q <= tot_q + TotW'(in_w);
        for (int c = 0; c < 3; c++) begin
          psum_q[c] <= psum_q[c] + PlainW'(in_ch[c]);
          wsum_q[c] <= wsum_q[c] + WSumW'(in_w) * WSumW'(in_ch[c]);
        end
        if (cnt_q == '0 || in_w > best_w_q) begin
          best_w_q <= in_w;
          best_q   <= in_rgb;
        end
      end else begin
        ovf_q <= 1'b1;
      end
    end
  end

  // sample ram
  logic [AddrW-1:0] rd_addr_q;
  rgb_t             rd_data;
  logic             rd_en, rvalid_q;
  logic [23:0]      rd_raw;

  assign rd_en = (state_q == ST_MED_RD);
  assign rd_data = rd_raw;

  vcr_ram #(
    .Width(24),
    .Depth(MAX_SAMPLES),
    .AddrW(AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (accept && room),
    .waddr_i(cnt_q[AddrW-1:0]),
    .wdata_i(in_rgb),
    .re_i   (rd_en),
    .raddr_i(rd_addr_q),
    .rdata_o(rd_raw)
  );

  // divider and median working registers
  logic [1:0]        ch_q;
  logic [2:0]        bit_q;
  logic [NumW-1:0]   rem_q;
  logic [DvsW-1:0]   dvs_q;
  logic [7:0]        quo_q;
  logic [7:0]        res_q [3];
  logic [7:0]        pre_q [2][3];
  logic [CntW-1:0]   rank_q [2][3];
  logic [CntW-1:0]   mcnt_q [2][3];
  logic              out_valid_q;
  logic [23:0]       out_data_q;
  logic              out_ovf_q;

  // dividend and divisor for the channel in work
  logic [NumW-1:0] num_sel, den_sel;
  always_comb begin
    if (method_q == METHOD_WEIGHTED && tot_q != '0) begin
      num_sel = NumW'(wsum_q[ch_q]);
      den_sel = NumW'(tot_q);
    end else begin
      num_sel = NumW'(psum_q[ch_q]);
      den_sel = NumW'(cnt_q);
    end
  end

  logic            div_ge;
  logic [DvsW-1:0] rem_ext;
  assign rem_ext = DvsW'(rem_q);
  assign div_ge = (rem_ext >= dvs_q);

  // median match of each stored channel against both current prefixes
  logic [7:0] rd_ch [3];
  assign rd_ch[0] = rd_data.red;
  assign rd_ch[1] = rd_data.green;
  assign rd_ch[2] = rd_data.blue;

  logic hit [2][3];
  always_comb begin
    logic [7:0] diff;
    for (int k = 0; k < 2; k++) begin
      for (int c = 0; c < 3; c++) begin
        diff = (rd_ch[c] ^ pre_q[k][c]) >> bit_q;
        hit[k][c] = (diff == 8'd0);
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;
  assign clear_vox = (state_q == ST_OUT) && out_free;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && s_axis_tlast) begin
          unique case (method_q)
            METHOD_BEST:   state_d = ST_OUT;
            METHOD_MEDIAN: state_d = ST_MED_RD;
            default:       state_d = ST_DIV_LD;
          endcase
        end
      end
      ST_DIV_LD:  state_d = ST_DIV_RUN;
      ST_DIV_RUN: begin
        if (bit_q == 3'd0) begin
          state_d = (ch_q == 2'd2) ? ST_OUT : ST_DIV_LD;
        end
      end
      ST_MED_RD: begin
        if (CntW'(rd_addr_q) + 1'b1 == cnt_q) begin
          state_d = ST_MED_WAIT;
        end
      end
      ST_MED_WAIT: state_d = ST_MED_BIT;
      ST_MED_BIT:  state_d = (bit_q == 3'd0) ? ST_OUT : ST_MED_RD;
      ST_OUT:      state_d = out_free ? ST_IDLE : ST_OUT;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= rd_en;
    end
  end

  // datapath of the finishing steps
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        ch_q      <= 2'd0;
        bit_q     <= 3'd7;
        rd_addr_q <= '0;
        for (int c = 0; c < 3; c++) begin
          for (int k = 0; k < 2; k++) begin
            pre_q[k][c]  <= 8'd0;
            mcnt_q[k][c] <= '0;
          end
          // ranks of the two middle items; equal for an odd count
          rank_q[0][c] <= (cnt_q + CntW'(room) - 1'b1) >> 1;
          rank_q[1][c] <= (cnt_q + CntW'(room)) >> 1;
        end
      end
      ST_DIV_LD: begin
        rem_q <= (num_sel << 1) + den_sel;
        dvs_q <= DvsW'(den_sel) << 8;
        quo_q <= 8'd0;
        bit_q <= 3'd7;
      end
      ST_DIV_RUN: begin
        if (div_ge) begin
          rem_q <= NumW'(rem_ext - dvs_q);
        end
        dvs_q <= dvs_q >> 1;
        quo_q <= {quo_q[6:0], div_ge};
        bit_q <= bit_q - 1'b1;
        if (bit_q == 3'd0) begin
          res_q[ch_q] <= {quo_q[6:0], div_ge};
          ch_q        <= ch_q + 1'b1;
        end
      end
      ST_MED_RD: begin
        rd_addr_q <= rd_addr_q + 1'b1;
      end
      ST_MED_WAIT: begin
        rd_addr_q <= '0;
      end
      ST_MED_BIT: begin
        for (int k = 0; k < 2; k++) begin
          for (int c = 0; c < 3; c++) begin
            mcnt_q[k][c] <= '0;
            if (rank_q[k][c] >= mcnt_q[k][c]) begin
              pre_q[k][c]  <= pre_q[k][c] | (8'd1 << bit_q);
              rank_q[k][c] <= rank_q[k][c] - mcnt_q[k][c];
            end
          end
        end
        bit_q <= bit_q - 1'b1;
      end
      ST_OUT: begin
        for (int c = 0; c < 3; c++) begin
          if (method_q == METHOD_MEDIAN) begin
            res_q[c] <= 8'((9'(pre_q[0][c]) + 9'(pre_q[1][c]) + 9'd1) >> 1);
          end
        end
      end
      default: begin
        ch_q <= 2'd0;
      end
    endcase

    // count the items below the tried bit during a pass
    if (rvalid_q) begin
      for (int k = 0; k < 2; k++) begin
        for (int c = 0; c < 3; c++) begin
          if (hit[k][c] && !rd_ch[c][bit_q]) begin
            mcnt_q[k][c] <= mcnt_q[k][c] + 1'b1;
          end
        end
      end
    end
  end

  // final color per channel: median from the prefixes after the last pass, best view, or divider result
  logic [7:0] fin_ch [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (method_q == METHOD_MEDIAN) begin
        fin_ch[c] = 8'((9'(pre_q[0][c]) + 9'(pre_q[1][c]) + 9'd1) >> 1);
      end else if (method_q == METHOD_BEST) begin
        fin_ch[c] = (c == 0) ? best_q.red : ((c == 1) ? best_q.green : best_q.blue);
      end else begin
        fin_ch[c] = res_q[c];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (clear_vox) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_vox) begin
      out_data_q <= {fin_ch[2], fin_ch[1], fin_ch[0]};
      out_ovf_q  <= ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_ovf_q;

endmodule

`default_nettype wire

/* sim/tb_voxel_color_reconstruction_top.sv */
// testbench for the voxel color reconstruction block: directed and random voxels of color samples
// are streamed in under all four color methods and each fused color is checked
// depends on vcr_pkg and voxel_color_reconstruction_top
`default_nettype none

// expected fused colors, kept as the voxels are fed in
class voxel_color_board;
  vcr_pkg::method_e method;
  bit [23:0] held[64];
  int unsigned count;
  longint unsigned sum[3];
  longint unsigned wsum[3];
  longint unsigned wtotal;
  bit [15:0] best_w;
  bit [23:0] best_rgb;
  bit dropped;
  bit [24:0] pending[$];
  int errors;

  function new();
    method = vcr_pkg::METHOD_AVERAGE;
    errors = 0;
    clear();
  endfunction

  function void clear();
    count = 0;
    wtotal = 0;
    best_w = 0;
    best_rgb = 0;
    dropped = 0;
    for (int c = 0; c < 3; c++) begin
      sum[c] = 0;
      wsum[c] = 0;
    end
  endfunction

  function bit [7:0] rounded(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (2 * num + den) / (2 * den);
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function bit [7:0] chan(bit [23:0] rgb, int c);
    return rgb[16 - 8 * c +: 8];
  endfunction

  // value of a given rank among the held samples of one channel
  function bit [7:0] ranked(int c, int unsigned r);
    int unsigned hist[256];
    int unsigned acc;
    for (int v = 0; v < 256; v++) hist[v] = 0;
    for (int i = 0; i < count; i++) hist[chan(held[i], c)]++;
    acc = 0;
    for (int v = 0; v < 256; v++) begin
      acc += hist[v];
      if (acc > r) return v[7:0];
    end
    return 8'd255;
  endfunction

  // note one accepted sample and, on the last one, queue the expected color
  function void take_sample(bit [23:0] rgb, bit [15:0] w, bit last);
    bit [23:0] res;
    if (count < 64) begin
      held[count] = rgb;
      for (int c = 0; c < 3; c++) begin
        sum[c] += chan(rgb, c);
        wsum[c] += longint'(w) * chan(rgb, c);
      end
      wtotal += w;
      if (count == 0 || w > best_w) begin
        best_w = w;
        best_rgb = rgb;
      end
      count++;
    end else begin
      dropped = 1;
    end
    if (!last) return;
    for (int c = 0; c < 3; c++) begin
      case (method)
        vcr_pkg::METHOD_BEST: res[16 - 8 * c +: 8] = chan(best_rgb, c);
        vcr_pkg::METHOD_WEIGHTED:
          res[16 - 8 * c +: 8] = (wtotal > 0) ? rounded(wsum[c], wtotal)
                                             : rounded(sum[c], count);
        vcr_pkg::METHOD_MEDIAN:
          if (count % 2) res[16 - 8 * c +: 8] = ranked(c, count / 2);
          else res[16 - 8 * c +: 8] =
            8'((9'(ranked(c, count / 2 - 1)) + 9'(ranked(c, count / 2)) + 9'd1) >> 1);
        default: res[16 - 8 * c +: 8] = rounded(sum[c], count);
      endcase
    end
    pending.push_back({dropped, res});
    clear();
  endfunction

  // compare one accepted color with the oldest expectation
  task check_color(bit [23:0] rgb, bit flag);
    bit [24:0] exp_v;
    if (pending.size() == 0) begin
      report($sformatf("unexpected color %h", rgb));
      return;
    end
    exp_v = pending.pop_front();
    for (int c = 0; c < 3; c++)
      if (chan(rgb, c) !== chan(exp_v[23:0], c))
        report($sformatf("channel %0d got %h expected %h", c, chan(rgb, c),
                         chan(exp_v[23:0], c)));
    if (flag !== exp_v[24])
      report($sformatf("capacity flag got %b expected %b", flag, exp_v[24]));
  endtask

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask
endclass

module tb_voxel_color_reconstruction_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 20000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic pready;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = 0;  // red, green, blue, view_weight
  logic s_axis_tlast = 0;         // final_sample
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [23:0] m_axis_tdata;      // out_red, out_green, out_blue
  logic m_axis_tuser;             // capacity_exceeded

  voxel_color_board board = new();
  int unsigned idle_cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned voxel_kind;

  voxel_color_reconstruction_top dut (.*);

  always #1 clk_i = ~clk_i;

  // receiver: stall pattern of its own, changed now and then
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= ~m_axis_tready;
      endcase
    end
  end

  // result check and watchdog; red travels in the low byte
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready)
      board.check_color({m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]},
                        m_axis_tuser);
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_method(vcr_pkg::method_e m);
    @(posedge clk_i);
    psel <= 1; pwrite <= 1; paddr <= 3'd0; pwdata <= 32'(m);
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.method = m;
  endtask

  // send one sample and wait until it is taken
  task automatic send_sample(bit [7:0] r, bit [7:0] g, bit [7:0] b, bit [15:0] w,
                             bit last);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {w, b, g, r};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_sample({r, g, b}, w, last);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic quiet();
    s_axis_tvalid <= 0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
  endtask

  // one random voxel; mostly few samples, sometimes past the store depth
  task automatic send_voxel();
    int unsigned n;
    int unsigned mode;
    bit [15:0] w;
    voxel_kind = $urandom_range(0, 19);
    n = (voxel_kind == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
    mode = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: w = '0;
        1: w = 16'($urandom_range(0, 3));
        default: w = 16'($urandom);
      endcase
      if (mode == 2 && $urandom_range(0, 3) == 0) w = 16'hffff;
      send_sample(8'($urandom), 8'($urandom), 8'($urandom), w, i == n - 1);
      maybe_gap();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes and special cases for every method
    for (int m = 0; m < 4; m++) begin
      write_method(vcr_pkg::method_e'(m));
      send_sample(8'hff, 8'h00, 8'hff, 16'h0000, 1);
      send_sample(8'h00, 8'hff, 8'h01, 16'h0000, 0);
      send_sample(8'hff, 8'h00, 8'hfe, 16'hffff, 0);
      send_sample(8'h10, 8'h20, 8'h30, 16'hffff, 1);
      send_sample(8'h01, 8'h02, 8'h03, 16'h0000, 0);
      send_sample(8'h02, 8'h03, 8'h04, 16'h0000, 1);
      quiet();
    end
    // store full: samples past the depth are dropped
    write_method(vcr_pkg::METHOD_MEDIAN);
    for (int i = 0; i < 66; i++)
      send_sample(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), i == 65);
    quiet();

    // random voxels, method changed between phases
    for (int ph = 0; ph < 8; ph++) begin
      write_method(vcr_pkg::method_e'((ph < 4) ? ph : $urandom_range(0, 3)));
      for (int v = 0; v < 25; v++) begin
        send_voxel();
        if ($urandom_range(0, 4) == 0) begin
          s_axis_tvalid <= 0;
          repeat ($urandom_range(1, 20)) @(posedge clk_i);
        end
      end
      quiet();
    end

    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* voxel_color_reconstruction_top.f */
rtl/core/vcr_pkg.sv
rtl/core/vcr_ram.sv
rtl/core/voxel_color_reconstruction_top.sv
sim/tb_voxel_color_reconstruction_top.sv
